/* hw/rtl/sitda_pkg.sv */
// Shared types and constants for the signed integer to decimal ASCII unit.
// No dependencies; used by sitda_bcd_cell and signed_int_to_decimal_ascii_unit.
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

    // ASCII codes that the unit emits
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Control word broadcast to every BCD cell of the chain
    typedef struct packed {
        logic clear;    // load zero into the digit
        logic dabble;   // add-3 correction, then shift one binary bit in
        logic advance;  // take the digit of the lower neighbor
    } t_cell_ctl;

    // Number of decimal digits of 2^(width-1), the largest magnitude.
    // Elaboration-time only.
    function automatic int f_num_digits(input int width);
        logic [64:0] v;
        int          n;
        v = 65'd1 << (width - 1);
        n = 0;
        while (v != 65'd0) begin
            v = v / 10;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/sitda_bcd_cell.sv */
// One BCD digit cell of the double-dabble chain.
// Depends on sitda_pkg (t_cell_ctl).
`timescale 1ns / 1ps
`default_nettype none

module sitda_bcd_cell (
    input  wire logic                 i_clk,
    input  wire sitda_pkg::t_cell_ctl i_ctl,
    input  wire logic                 i_bit_in,    // binary bit from lower cell
    input  wire logic [3:0]           i_digit_in,  // digit from lower cell
    output logic                      o_bit_out,   // binary bit to upper cell
    output logic [3:0]                o_digit
);

    logic [3:0] r_digit;
    logic [3:0] w_corr;

    // Add 3 when the digit would overflow past 9 after doubling
    assign w_corr    = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_bit_out = w_corr[3];
    assign o_digit   = r_digit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_digit <= 4'd0;
        end else if (i_ctl.dabble) begin
            r_digit <= {w_corr[2:0], i_bit_in};
        end else if (i_ctl.advance) begin
            r_digit <= i_digit_in;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/signed_int_to_decimal_ascii_unit.sv */
// Top level: signed integer to decimal ASCII text, one character per transfer.
// Depends on sitda_pkg and sitda_bcd_cell.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Signals                                 Transfer when
// input    in         i_in_valid, o_in_ready, i_value         i_in_valid & o_in_ready
// output   out        o_out_valid, i_out_ready, o_char_code,  o_out_valid & i_out_ready
//                     o_is_last
//
// A value is taken in, shifted into the chain of BCD cells (one binary bit per cycle,
// MSB first), stripped of its leading zeros with the units digit always kept, then
// sent out one character per transfer, a minus sign first if the value is negative.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and empties
// the output register. A stalled output holds the chain; a new value is taken
// in the cycle after the previous one has handed its last character to the register.

module signed_int_to_decimal_ascii_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [7:0]                  o_char_code,
    output logic                        o_is_last
);

    localparam int NDIG   = sitda_pkg::f_num_digits(VALUE_WIDTH);
    localparam int CNT_W  = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int LEFT_W = $clog2(NDIG + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic [VALUE_WIDTH-1:0]  r_mag;
    logic                    r_neg;
    logic [CNT_W-1:0]        r_cnt;
    logic [LEFT_W-1:0]       r_left;
    logic                    r_out_valid;
    logic [7:0]              r_char;
    logic                    r_last;

    logic                    w_in_xfer;
    logic                    w_slot_free;
    logic                    w_top_zero;
    logic [VALUE_WIDTH-1:0]  w_mag;
    sitda_pkg::t_cell_ctl    w_ctl;
    logic [3:0]              w_digit [NDIG];
    logic                    w_carry [NDIG];

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_top_zero  = (w_digit[NDIG-1] == 4'd0);
    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_is_last   = r_last;

    // Unsigned magnitude; the most negative value maps to 2^(W-1)
    assign w_mag = i_value[VALUE_WIDTH-1] ? (~i_value + 1'b1) : i_value;

    // Chain control
    always_comb begin
        w_ctl.clear   = w_in_xfer;
        w_ctl.dabble  = (r_state == S_CONV);
        w_ctl.advance = ((r_state == S_SKIP) && w_top_zero && (r_left > LEFT_W'(1)))
                     || ((r_state == S_EMIT) && !r_neg && w_slot_free);
    end

    // Row of BCD cells, cell 0 is the least significant digit
    for (genvar k = 0; k < NDIG; k++) begin : g_cell
        if (k == 0) begin : g_low
            sitda_bcd_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_bit_in   (r_mag[VALUE_WIDTH-1]),
                .i_digit_in (4'd0),
                .o_bit_out  (w_carry[k]),
                .o_digit    (w_digit[k])
            );
        end else begin : g_up
            sitda_bcd_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_bit_in   (w_carry[k-1]),
                .i_digit_in (w_digit[k-1]),
                .o_bit_out  (w_carry[k]),
                .o_digit    (w_digit[k])
            );
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // in S_EMIT the register is refilled whenever it empties
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_mag   <= w_mag;
                        r_neg   <= i_value[VALUE_WIDTH-1];
                        r_cnt   <= CNT_W'(VALUE_WIDTH - 1);
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_mag <= r_mag << 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_left  <= LEFT_W'(NDIG);
                        r_state <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    // drop leading zeros, always keep the units digit
                    if (w_top_zero && (r_left > LEFT_W'(1))) begin
                        r_left <= r_left - 1'b1;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        if (r_neg) begin
                            r_char <= sitda_pkg::CHAR_MINUS;
                            r_last <= 1'b0;
                            r_neg  <= 1'b0;
                        end else begin
                            r_char <= sitda_pkg::CHAR_ZERO + {4'd0, w_digit[NDIG-1]};
                            r_last <= (r_left == LEFT_W'(1));
                            r_left <= r_left - 1'b1;
                            if (r_left == LEFT_W'(1)) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* dv/decimal_text_checker.sv */
// Checker for signed_int_to_decimal_ascii_unit: watches both channels, predicts the text.
// Depends on sitda_pkg for the ASCII codes of the zero digit and the minus sign.
`timescale 1ns / 1ps

module decimal_text_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [7:0]             i_char_code,
    input  logic                   i_is_last,
    output int                     o_fail_count,
    output int                     o_pending
);

    // One expected character of the text
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_text_char;

    t_text_char chars_due[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        if (o_fail_count < 100) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    // Decimal text of one value: sign first, then digits, MSD first
    task automatic queue_decimal_text(input logic [VALUE_WIDTH-1:0] value);
        logic                   negative;
        logic [VALUE_WIDTH-1:0] magnitude;
        logic [7:0]             digit_codes[$];
        t_text_char             c;
        negative  = value[VALUE_WIDTH-1];
        // unsigned magnitude, so the most negative value needs no special handling
        magnitude = negative ? (~value + 1'b1) : value;
        do begin
            digit_codes.push_front(sitda_pkg::CHAR_ZERO + 8'(magnitude % 10));
            magnitude = magnitude / 10;
        end while (magnitude != 0);
        if (negative) begin
            c.code = sitda_pkg::CHAR_MINUS;
            c.last = 1'b0;
            chars_due.push_back(c);
        end
        foreach (digit_codes[i]) begin
            c.code = digit_codes[i];
            c.last = (i == digit_codes.size() - 1);
            chars_due.push_back(c);
        end
    endtask

    // Compare output transfers, predict on input transfers
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (chars_due.size() == 0) begin
                    report_mismatch($sformatf("char %h last %b with nothing due",
                                              i_char_code, i_is_last));
                end else begin
                    want = chars_due.pop_front();
                    if (i_char_code !== want.code) begin
                        report_mismatch($sformatf("char_code %h, want %h",
                                                  i_char_code, want.code));
                    end
                    if (i_is_last !== want.last) begin
                        report_mismatch($sformatf("is_last %b, want %b on char %h",
                                                  i_is_last, want.last, want.code));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                queue_decimal_text(i_value);
            end
            o_pending <= chars_due.size();
        end
    end

endmodule

/* dv/testbench.sv */
// Top of the testbench for signed_int_to_decimal_ascii_unit: clock, reset, stimulus, verdict.
// Depends on the unit, sitda_pkg and decimal_text_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int VALUE_WIDTH      = 32;
    localparam int RANDOM_PER_PHASE = 130;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int DRAIN_CYCLES     = 60;
    localparam int NUM_PHASES       = 3;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [VALUE_WIDTH-1:0] i_value;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [7:0]             o_char_code;
    logic                   o_is_last;

    int fail_count;
    int pending_chars;
    int cycle_count;
    int sender_idle_pct;
    int receiver_stall_pct;

    // Idle percentages per phase: sender then receiver
    int sender_idle_by_phase[NUM_PHASES]    = '{8, 64, 0};
    int receiver_stall_by_phase[NUM_PHASES] = '{64, 8, 0};

    // Extremes, sign edges, digit count edges and bit patterns
    logic [VALUE_WIDTH-1:0] directed_values[] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
        32'd100, -32'sd100, 32'd12345, -32'sd67890, 32'd999999999,
        32'd1000000000, -32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0001,
        32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFE, -32'sd7
    };

    signed_int_to_decimal_ascii_unit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_char_code (o_char_code),
        .o_is_last   (o_is_last)
    );

    decimal_text_checker #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_char_code  (o_char_code),
        .i_is_last    (o_is_last),
        .o_fail_count (fail_count),
        .o_pending    (pending_chars)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random stalls at the current rate
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Mostly shaped magnitudes: small, random digit count, near powers of ten, near the extremes
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        logic [VALUE_WIDTH-1:0] mag;
        logic [VALUE_WIDTH-1:0] decade;
        int                     k;
        decade = 1;
        k = $urandom_range(1, 9);
        for (int i = 0; i < k; i++) begin
            decade = decade * 10;
        end
        case ($urandom_range(0, 5))
            0, 1: return $urandom();
            2: mag = $urandom_range(0, 999);
            3: mag = $urandom_range(0, decade - 1);
            4: mag = decade + $urandom_range(0, 2) - 1;
            default: mag = 32'h8000_0000 - $urandom_range(0, 15);
        endcase
        if ($urandom_range(0, 1)) begin
            mag = ~mag + 1'b1;
        end
        return mag;
    endfunction

    // One input transfer, with a random gap ahead of it
    task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= value;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    // Hold the sender until every expected character has arrived
    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_chars != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Reset, then three phases of stimulus with different idle rates
    initial begin
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_value            = '0;
        i_out_ready        = 1'b0;
        cycle_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            sender_idle_pct    = sender_idle_by_phase[phase];
            receiver_stall_pct = receiver_stall_by_phase[phase];
            if (phase == 0) begin
                foreach (directed_values[i]) begin
                    send_value(directed_values[i]);
                end
            end
            repeat (RANDOM_PER_PHASE) begin
                send_value(pick_value());
            end
            pause_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_chars == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
